>>> rtl/core/ssc_pkg.sv
// Shared types, constants and codes for the string similarity scorer.
package ssc_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int CH_W        = 8;
    localparam int ALPHA       = 256;
    localparam int ALPHA_W     = 8;
    localparam int SC_W        = 17;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * SC_W;
    localparam int SQ_RW       = SC_W + 3;
    localparam int SHR_W       = 9;
    localparam int STEP_W      = 5;

    localparam logic [SC_W-1:0] Q_ONE = 17'h1_0000;

    typedef enum logic [1:0] {
        OP_APP_FIRST  = 2'd0,
        OP_APP_SECOND = 2'd1,
        OP_COMPARE    = 2'd2
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic text_busy;
    } t_back_stat;

    typedef enum logic [1:0] {
        PH_HIST1,
        PH_HIST2,
        PH_FILT1,
        PH_FILT2
    } t_bph;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_CLEAR,
        BS_TREAD,
        BS_HREAD,
        BS_UPDATE,
        BS_PASS,
        BS_OREAD,
        BS_OCMP,
        BS_ODIV,
        BS_OWAIT,
        BS_LDIV,
        BS_LWAIT,
        BS_MUL,
        BS_SQRT,
        BS_SWAIT,
        BS_DONE
    } t_bst;

endpackage

>>> rtl/core/string_similarity_score.sv
// Top level of the string similarity scorer: front end, command queue, text buffers, back end.
//
//  channel  | direction | handshake          | words
//  ---------+-----------+--------------------+------------------------------------------
//  command  | in        | i_valid / o_stall  | i_opcode, i_character
//  result   | out       | o_valid / i_stall  | o_similarity, o_letter_part, o_order_part,
//           |           |                    | o_shared_count, o_overflowed
//
//  A compare clears all 256 entries of both histograms, walks the buffers four times
//  (each character read, then its histogram entry read and updated), runs the
//  matching passes (each element read, then compared), then up to two divides and a
//  square root. Reset is synchronous and active low; it empties the queue, the
//  buffers' lengths and the result register. Appends stall while a compare is queued
//  or still reading the text buffers; a compare stalls only when the queue is full.
//  A finished result waits in its register without blocking new appends.
module string_similarity_score #(
    parameter int  MAX_LEN = ssc_pkg::MAX_LEN_DEF,
    localparam int LW      = $clog2(MAX_LEN + 1),
    localparam int AW      = $clog2(MAX_LEN),
    localparam int EW      = 2 * LW + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_opcode,
    input  logic [ssc_pkg::CH_W-1:0]  i_character,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ssc_pkg::SC_W-1:0]  o_similarity,
    output logic [ssc_pkg::SC_W-1:0]  o_letter_part,
    output logic [ssc_pkg::SC_W-1:0]  o_order_part,
    output logic [ssc_pkg::SHR_W-1:0] o_shared_count,
    output logic                      o_overflowed
);

    ssc_pkg::t_back_stat        back_stat;
    ssc_pkg::t_q_stat           q_stat;
    logic                       q_push, q_pop;
    logic [EW-1:0]              q_in, q_out;
    logic                       we_first, we_second;
    logic [AW-1:0]              text_waddr, text_raddr;
    logic [ssc_pkg::CH_W-1:0]   text_wdata, first_rd, second_rd;

    // front end: owns the string lengths and the drop flag
    ssc_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_character (i_character),
        .i_back      (back_stat),
        .i_q         (q_stat),
        .o_push      (q_push),
        .o_cmd       (q_in),
        .o_we_first  (we_first),
        .o_we_second (we_second),
        .o_waddr     (text_waddr),
        .o_wdata     (text_wdata)
    );

    // compare commands carry a snapshot of both lengths and the drop flag
    ssc_fifo #(.EW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    // text buffers: written by the front end, walked by the back end
    ssc_ram #(.WIDTH(ssc_pkg::CH_W), .DEPTH(MAX_LEN)) u_text1 (
        .i_clk(i_clk), .i_we(we_first), .i_waddr(text_waddr), .i_wdata(text_wdata),
        .i_raddr(text_raddr), .o_rdata(first_rd)
    );
    ssc_ram #(.WIDTH(ssc_pkg::CH_W), .DEPTH(MAX_LEN)) u_text2 (
        .i_clk(i_clk), .i_we(we_second), .i_waddr(text_waddr), .i_wdata(text_wdata),
        .i_raddr(text_raddr), .o_rdata(second_rd)
    );

    ssc_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (q_out),
        .i_q            (q_stat),
        .o_pop          (q_pop),
        .o_stat         (back_stat),
        .o_text_raddr   (text_raddr),
        .i_first_rdata  (first_rd),
        .i_second_rdata (second_rd),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_similarity   (o_similarity),
        .o_letter_part  (o_letter_part),
        .o_order_part   (o_order_part),
        .o_shared_count (o_shared_count),
        .o_overflowed   (o_overflowed)
    );

    // geometric mean never exceeds the larger of its two factors
    a_sim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_similarity <= o_letter_part || o_similarity <= o_order_part))
        else $error("similarity above both part scores");

    // no shared distribution means no similarity
    a_zero_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_letter_part == '0) |-> (o_similarity == '0))
        else $error("similarity nonzero with zero letter score");

    // the text buffers are never written while the back end walks them
    a_text_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_first || we_second) |-> (!back_stat.text_busy && q_stat.empty))
        else $error("text buffer written during compare");

endmodule

>>> rtl/core/ssc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ssc_fifo.sv
// Two-entry queue of compare commands between front and back.
module ssc_fifo #(
    parameter int EW = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [EW-1:0]    i_data,
    input  logic             i_pop,
    output logic [EW-1:0]    o_data,
    output ssc_pkg::t_q_stat o_stat
);

    logic [EW-1:0] r_data [2];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    assign o_data       = r_data[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

endmodule

>>> rtl/core/ssc_front.sv
// Front end: takes words, writes the text buffers, queues compare commands.
module ssc_front #(
    parameter int  MAX_LEN = ssc_pkg::MAX_LEN_DEF,
    localparam int LW      = $clog2(MAX_LEN + 1),
    localparam int AW      = $clog2(MAX_LEN),
    localparam int EW      = 2 * LW + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_opcode,
    input  logic [ssc_pkg::CH_W-1:0]  i_character,
    input  ssc_pkg::t_back_stat       i_back,
    input  ssc_pkg::t_q_stat          i_q,
    output logic                      o_push,
    output logic [EW-1:0]             o_cmd,
    output logic                      o_we_first,
    output logic                      o_we_second,
    output logic [AW-1:0]             o_waddr,
    output logic [ssc_pkg::CH_W-1:0]  o_wdata
);

    logic [LW-1:0] r_len1, n_len1;
    logic [LW-1:0] r_len2, n_len2;
    logic          r_drop, n_drop;
    logic          is_app;

    always_comb begin
        n_len1      = r_len1;
        n_len2      = r_len2;
        n_drop      = r_drop;
        o_push      = 1'b0;
        o_we_first  = 1'b0;
        o_we_second = 1'b0;
        o_waddr     = '0;
        o_wdata     = i_character;
        o_cmd       = {r_len1, r_len2, r_drop};
        is_app      = (i_opcode == ssc_pkg::OP_APP_FIRST) ||
                      (i_opcode == ssc_pkg::OP_APP_SECOND);
        // texts belong to the back end while a compare is queued or reading
        o_stall     = i_q.full || (is_app && (!i_q.empty || i_back.text_busy));
        if (i_valid && !o_stall) begin
            unique case (i_opcode)
                ssc_pkg::OP_APP_FIRST: begin
                    if (r_len1 < LW'(MAX_LEN)) begin
                        o_we_first = 1'b1;
                        o_waddr    = r_len1[AW-1:0];
                        n_len1     = r_len1 + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                ssc_pkg::OP_APP_SECOND: begin
                    if (r_len2 < LW'(MAX_LEN)) begin
                        o_we_second = 1'b1;
                        o_waddr     = r_len2[AW-1:0];
                        n_len2      = r_len2 + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                ssc_pkg::OP_COMPARE: begin
                    o_push = 1'b1;
                    n_len1 = '0;
                    n_len2 = '0;
                    n_drop = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= '0;
            r_len2 <= '0;
            r_drop <= 1'b0;
        end else begin
            r_len1 <= n_len1;
            r_len2 <= n_len2;
            r_drop <= n_drop;
        end
    end

endmodule

>>> rtl/core/ssc_div.sv
// Restoring divider, one quotient bit per cycle, for a dividend not above the divisor.
module ssc_div #(
    parameter int DW = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_num,
    input  logic [DW-1:0]            i_den,
    output logic                     o_done,
    output logic [ssc_pkg::SC_W-1:0] o_quo
);

    logic [DW-1:0]                r_rem, n_rem;
    logic [DW-1:0]                r_den, n_den;
    logic [ssc_pkg::SC_W-1:0]     r_q, n_q;
    logic [ssc_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    logic                         r_run, n_run;
    logic                         r_done, n_done;
    logic [DW:0]                  sh;
    logic                         ge;

    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        sh     = {r_rem, 1'b0};
        ge     = (i_num >= i_den);
        if (i_start) begin
            n_den = i_den;
            n_rem = ge ? (i_num - i_den) : i_num;
            n_q   = ssc_pkg::SC_W'(ge);
            n_cnt = ssc_pkg::STEP_W'(ssc_pkg::FRAC_W);
            n_run = 1'b1;
        end else if (r_run) begin
            if (sh >= {1'b0, r_den}) begin
                n_rem = DW'(sh - {1'b0, r_den});
                n_q   = {r_q[ssc_pkg::SC_W-2:0], 1'b1};
            end else begin
                n_rem = sh[DW-1:0];
                n_q   = {r_q[ssc_pkg::SC_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ssc_pkg::STEP_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

>>> rtl/core/ssc_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module ssc_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ssc_pkg::PROD_W-1:0] i_x,
    output logic                       o_done,
    output logic [ssc_pkg::SC_W-1:0]   o_root
);

    logic [ssc_pkg::PROD_W-1:0] r_x, n_x;
    logic [ssc_pkg::SQ_RW-1:0]  r_rem, n_rem;
    logic [ssc_pkg::SC_W-1:0]   r_root, n_root;
    logic [ssc_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                       r_run, n_run;
    logic                       r_done, n_done;
    logic [ssc_pkg::SQ_RW-1:0]  cur;
    logic [ssc_pkg::SQ_RW-1:0]  trial;

    always_comb begin
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        cur    = {r_rem[ssc_pkg::SQ_RW-3:0], r_x[ssc_pkg::PROD_W-1 -: 2]};
        trial  = ssc_pkg::SQ_RW'({r_root, 2'b01});
        if (i_start) begin
            n_x    = i_x;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = ssc_pkg::STEP_W'(ssc_pkg::SC_W);
            n_run  = 1'b1;
        end else if (r_run) begin
            n_x = {r_x[ssc_pkg::PROD_W-3:0], 2'b00};
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {r_root[ssc_pkg::SC_W-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {r_root[ssc_pkg::SC_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ssc_pkg::STEP_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/core/ssc_back.sv
// Back end: histograms, shared-character filtering, pass count, scores, result register.
module ssc_back #(
    parameter int  MAX_LEN = ssc_pkg::MAX_LEN_DEF,
    localparam int LW      = $clog2(MAX_LEN + 1),
    localparam int AW      = $clog2(MAX_LEN),
    localparam int EW      = 2 * LW + 1,
    localparam int DW      = LW + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [EW-1:0]              i_q_data,
    input  ssc_pkg::t_q_stat           i_q,
    output logic                       o_pop,
    output ssc_pkg::t_back_stat        o_stat,
    output logic [AW-1:0]              o_text_raddr,
    input  logic [ssc_pkg::CH_W-1:0]   i_first_rdata,
    input  logic [ssc_pkg::CH_W-1:0]   i_second_rdata,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ssc_pkg::SC_W-1:0]   o_similarity,
    output logic [ssc_pkg::SC_W-1:0]   o_letter_part,
    output logic [ssc_pkg::SC_W-1:0]   o_order_part,
    output logic [ssc_pkg::SHR_W-1:0]  o_shared_count,
    output logic                       o_overflowed
);

    ssc_pkg::t_bst r_st, n_st;
    ssc_pkg::t_bph r_ph, n_ph;

    logic [LW-1:0]                r_len1, n_len1;
    logic [LW-1:0]                r_len2, n_len2;
    logic                         r_drop, n_drop;
    logic [ssc_pkg::ALPHA_W-1:0]  r_cidx, n_cidx;
    logic [LW-1:0]                r_idx, n_idx;
    logic [ssc_pkg::CH_W-1:0]     r_ch, n_ch;
    logic [LW-1:0]                r_n, n_n;
    logic [LW-1:0]                r_m, n_m;
    logic [LW-1:0]                r_i1, n_i1;
    logic [LW-1:0]                r_i2, n_i2;
    logic [LW-1:0]                r_before, n_before;
    logic [LW-1:0]                r_pass, n_pass;
    logic [ssc_pkg::SC_W-1:0]     r_letter, n_letter;
    logic [ssc_pkg::SC_W-1:0]     r_order, n_order;
    logic [ssc_pkg::PROD_W-1:0]   r_prod, n_prod;

    logic                         r_ov, n_ov;
    logic [ssc_pkg::SC_W-1:0]     r_o_sim, n_o_sim;
    logic [ssc_pkg::SC_W-1:0]     r_o_let, n_o_let;
    logic [ssc_pkg::SC_W-1:0]     r_o_ord, n_o_ord;
    logic [ssc_pkg::SHR_W-1:0]    r_o_shr, n_o_shr;
    logic                         r_o_ovf, n_o_ovf;

    // histogram and filtered-string RAM ports
    logic                         h1_we, h2_we;
    logic [ssc_pkg::ALPHA_W-1:0]  h_waddr, h_raddr;
    logic [LW-1:0]                h_wdata, h1_rd, h2_rd;
    logic                         cf_we, cs_we;
    logic [AW-1:0]                cf_waddr, cs_waddr, cf_raddr, cs_raddr;
    logic [ssc_pkg::CH_W-1:0]     cf_wdata, cf_rd;
    logic [ssc_pkg::CH_W:0]       cs_wdata, cs_rd;

    logic                         div_start, div_done;
    logic [DW-1:0]                div_num, div_den;
    logic [ssc_pkg::SC_W-1:0]     div_q;
    logic                         sq_start, sq_done;
    logic [ssc_pkg::SC_W-1:0]     sq_root;

    logic                         sel_second, use_h2, is_filt, hit;
    logic [LW-1:0]                cur_len, hist_v, i1_nx, i2_nx, pass_cl;
    logic [ssc_pkg::CH_W-1:0]     text_ch;
    logic [DW-1:0]                total;

    ssc_ram #(.WIDTH(LW), .DEPTH(ssc_pkg::ALPHA)) u_hist1 (
        .i_clk(i_clk), .i_we(h1_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h1_rd)
    );
    ssc_ram #(.WIDTH(LW), .DEPTH(ssc_pkg::ALPHA)) u_hist2 (
        .i_clk(i_clk), .i_we(h2_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h2_rd)
    );
    ssc_ram #(.WIDTH(ssc_pkg::CH_W), .DEPTH(MAX_LEN)) u_common1 (
        .i_clk(i_clk), .i_we(cf_we), .i_waddr(cf_waddr), .i_wdata(cf_wdata),
        .i_raddr(cf_raddr), .o_rdata(cf_rd)
    );
    // top bit marks an entry already matched in this compare
    ssc_ram #(.WIDTH(ssc_pkg::CH_W + 1), .DEPTH(MAX_LEN)) u_common2 (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_raddr(cs_raddr), .o_rdata(cs_rd)
    );

    ssc_div #(.DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quo(div_q)
    );

    ssc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_x(r_prod),
        .o_done(sq_done), .o_root(sq_root)
    );

    always_comb begin
        sel_second = (r_ph == ssc_pkg::PH_HIST2) || (r_ph == ssc_pkg::PH_FILT2);
        use_h2     = (r_ph == ssc_pkg::PH_HIST2) || (r_ph == ssc_pkg::PH_FILT1);
        is_filt    = (r_ph == ssc_pkg::PH_FILT1) || (r_ph == ssc_pkg::PH_FILT2);
        cur_len    = sel_second ? r_len2 : r_len1;
        text_ch    = sel_second ? i_second_rdata : i_first_rdata;
        hist_v     = use_h2 ? h2_rd : h1_rd;
        hit        = !cs_rd[ssc_pkg::CH_W] && (cs_rd[ssc_pkg::CH_W-1:0] == cf_rd);
        i1_nx      = r_i1 + LW'(hit);
        i2_nx      = r_i2 + 1'b1;
        pass_cl    = (r_pass > r_n) ? r_n : r_pass;
        total      = DW'(r_len1) + DW'(r_len2);

        n_st = r_st; n_ph = r_ph; n_len1 = r_len1; n_len2 = r_len2; n_drop = r_drop;
        n_cidx = r_cidx; n_idx = r_idx; n_ch = r_ch; n_n = r_n; n_m = r_m;
        n_i1 = r_i1; n_i2 = r_i2; n_before = r_before; n_pass = r_pass;
        n_letter = r_letter; n_order = r_order; n_prod = r_prod;
        n_o_sim = r_o_sim; n_o_let = r_o_let; n_o_ord = r_o_ord;
        n_o_shr = r_o_shr; n_o_ovf = r_o_ovf;
        n_ov = r_ov && i_stall;

        o_pop        = 1'b0;
        o_text_raddr = r_idx[AW-1:0];
        h1_we    = 1'b0;
        h2_we    = 1'b0;
        h_waddr  = r_ch;
        h_raddr  = text_ch;
        h_wdata  = hist_v + 1'b1;
        cf_we    = 1'b0;
        cf_waddr = r_n[AW-1:0];
        cf_wdata = r_ch;
        cs_we    = 1'b0;
        cs_waddr = r_m[AW-1:0];
        cs_wdata = {1'b0, r_ch};
        cf_raddr = r_i1[AW-1:0];
        cs_raddr = r_i2[AW-1:0];
        div_start = 1'b0;
        div_num   = DW'({r_n, 1'b0});
        div_den   = total;
        sq_start  = 1'b0;

        unique case (r_st)
            ssc_pkg::BS_IDLE: begin
                if (!i_q.empty) begin
                    o_pop  = 1'b1;
                    n_len1 = i_q_data[EW-1 -: LW];
                    n_len2 = i_q_data[LW:1];
                    n_drop = i_q_data[0];
                    n_cidx = '0;
                    n_idx  = '0;
                    n_n    = '0;
                    n_m    = '0;
                    n_ph   = ssc_pkg::PH_HIST1;
                    n_st   = ssc_pkg::BS_CLEAR;
                end
            end
            ssc_pkg::BS_CLEAR: begin
                h1_we   = 1'b1;
                h2_we   = 1'b1;
                h_waddr = r_cidx;
                h_wdata = '0;
                n_cidx  = r_cidx + 1'b1;
                if (r_cidx == '1) begin
                    n_st = ssc_pkg::BS_TREAD;
                end
            end
            ssc_pkg::BS_TREAD: begin
                if (r_idx == cur_len) begin
                    n_idx = '0;
                    unique case (r_ph)
                        ssc_pkg::PH_HIST1: n_ph = ssc_pkg::PH_HIST2;
                        ssc_pkg::PH_HIST2: n_ph = ssc_pkg::PH_FILT1;
                        ssc_pkg::PH_FILT1: n_ph = ssc_pkg::PH_FILT2;
                        ssc_pkg::PH_FILT2: begin
                            if (r_n == '0) begin
                                n_order = '0;
                                n_st    = ssc_pkg::BS_LDIV;
                            end else if (r_n == LW'(1)) begin
                                n_order = ssc_pkg::Q_ONE;
                                n_st    = ssc_pkg::BS_LDIV;
                            end else begin
                                n_i1   = '0;
                                n_pass = '0;
                                n_st   = ssc_pkg::BS_PASS;
                            end
                        end
                    endcase
                end else begin
                    n_st = ssc_pkg::BS_HREAD;
                end
            end
            ssc_pkg::BS_HREAD: begin
                n_ch = text_ch;
                n_st = ssc_pkg::BS_UPDATE;
            end
            ssc_pkg::BS_UPDATE: begin
                if (!is_filt) begin
                    h1_we = !use_h2;
                    h2_we = use_h2;
                end else if (hist_v != '0) begin
                    h_wdata = hist_v - 1'b1;
                    h1_we   = !use_h2;
                    h2_we   = use_h2;
                    if (r_ph == ssc_pkg::PH_FILT1) begin
                        cf_we = 1'b1;
                        n_n   = r_n + 1'b1;
                    end else begin
                        cs_we = 1'b1;
                        n_m   = r_m + 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
                n_st  = ssc_pkg::BS_TREAD;
            end
            ssc_pkg::BS_PASS: begin
                n_before = r_i1;
                n_pass   = r_pass + 1'b1;
                n_i2     = '0;
                n_st     = ssc_pkg::BS_OREAD;
            end
            ssc_pkg::BS_OREAD: begin
                n_st = ssc_pkg::BS_OCMP;
            end
            ssc_pkg::BS_OCMP: begin
                if (hit) begin
                    cs_we    = 1'b1;
                    cs_waddr = r_i2[AW-1:0];
                    cs_wdata = {1'b1, cs_rd[ssc_pkg::CH_W-1:0]};
                end
                n_i1 = i1_nx;
                n_i2 = i2_nx;
                if ((i2_nx == r_n) || (i1_nx == r_n)) begin
                    if ((i1_nx == r_n) || (i1_nx == r_before)) begin
                        n_st = ssc_pkg::BS_ODIV;
                    end else begin
                        n_st = ssc_pkg::BS_PASS;
                    end
                end else begin
                    n_st = ssc_pkg::BS_OREAD;
                end
            end
            ssc_pkg::BS_ODIV: begin
                div_start = 1'b1;
                div_num   = DW'(r_n - pass_cl);
                div_den   = DW'(r_n - 1'b1);
                n_st      = ssc_pkg::BS_OWAIT;
            end
            ssc_pkg::BS_OWAIT: begin
                if (div_done) begin
                    n_order = div_q;
                    n_st    = ssc_pkg::BS_LDIV;
                end
            end
            ssc_pkg::BS_LDIV: begin
                if (total == '0) begin
                    n_letter = '0;
                    n_st     = ssc_pkg::BS_MUL;
                end else begin
                    div_start = 1'b1;
                    n_st      = ssc_pkg::BS_LWAIT;
                end
            end
            ssc_pkg::BS_LWAIT: begin
                if (div_done) begin
                    n_letter = div_q;
                    n_st     = ssc_pkg::BS_MUL;
                end
            end
            ssc_pkg::BS_MUL: begin
                n_prod = r_letter * r_order;
                n_st   = ssc_pkg::BS_SQRT;
            end
            ssc_pkg::BS_SQRT: begin
                sq_start = 1'b1;
                n_st     = ssc_pkg::BS_SWAIT;
            end
            ssc_pkg::BS_SWAIT: begin
                if (sq_done) begin
                    n_st = ssc_pkg::BS_DONE;
                end
            end
            ssc_pkg::BS_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_o_sim = sq_root;
                    n_o_let = r_letter;
                    n_o_ord = r_order;
                    n_o_shr = ssc_pkg::SHR_W'(r_n);
                    n_o_ovf = r_drop;
                    n_st    = ssc_pkg::BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ssc_pkg::BS_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph     <= n_ph;
        r_len1   <= n_len1;
        r_len2   <= n_len2;
        r_drop   <= n_drop;
        r_cidx   <= n_cidx;
        r_idx    <= n_idx;
        r_ch     <= n_ch;
        r_n      <= n_n;
        r_m      <= n_m;
        r_i1     <= n_i1;
        r_i2     <= n_i2;
        r_before <= n_before;
        r_pass   <= n_pass;
        r_letter <= n_letter;
        r_order  <= n_order;
        r_prod   <= n_prod;
        r_o_sim  <= n_o_sim;
        r_o_let  <= n_o_let;
        r_o_ord  <= n_o_ord;
        r_o_shr  <= n_o_shr;
        r_o_ovf  <= n_o_ovf;
    end

    assign o_stat.text_busy = (r_st == ssc_pkg::BS_CLEAR) || (r_st == ssc_pkg::BS_TREAD) ||
                              (r_st == ssc_pkg::BS_HREAD) || (r_st == ssc_pkg::BS_UPDATE);

    assign o_valid        = r_ov;
    assign o_similarity   = r_o_sim;
    assign o_letter_part  = r_o_let;
    assign o_order_part   = r_o_ord;
    assign o_shared_count = r_o_shr;
    assign o_overflowed   = r_o_ovf;

endmodule
